[rtl/core/mckb_pkg.sv]
// ----------------------------------------------------------------------------
// mckb_pkg
// shared types and constants of the masked color-key blitter
// ----------------------------------------------------------------------------
package mckb_pkg;

  // largest image side in pixels, larger programmed sizes saturate here
  localparam int unsigned MaxDim  = 4096;
  // width of a programmed size field
  localparam int unsigned DimW    = 13;
  // width of a window / destination coordinate
  localparam int unsigned CoordW  = 12;
  // width of a programmed origin
  localparam int unsigned OrigW   = 14;
  localparam int unsigned PixW    = 32;
  localparam int unsigned AddrW   = 5;

  localparam logic [DimW-1:0]  MaxDimVal   = DimW'(MaxDim);
  localparam logic [PixW-1:0]  OpaqueBlack = 32'h0000_00FF;

  // register map, byte address is 4 * index
  typedef enum logic [2:0] {
    RegDstOriginX = 3'd0,
    RegDstOriginY = 3'd1,
    RegSrcOriginX = 3'd2,
    RegSrcOriginY = 3'd3,
    RegKeyColor   = 3'd4,
    RegDstDims    = 3'd5,
    RegSrcDims    = 3'd6,
    RegMaskDims   = 3'd7
  } reg_idx_e;

  // decoded configuration, sizes already saturated
  typedef struct packed {
    logic signed [OrigW-1:0] dst_x;
    logic signed [OrigW-1:0] dst_y;
    logic signed [OrigW-1:0] src_x;
    logic signed [OrigW-1:0] src_y;
    logic [PixW-1:0]         key;
    logic [DimW-1:0]         dst_w;
    logic [DimW-1:0]         dst_h;
    logic [DimW-1:0]         src_w;
    logic [DimW-1:0]         src_h;
    logic [DimW-1:0]         mask_w;
    logic [DimW-1:0]         mask_h;
  } cfg_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] d);
    return (d > MaxDimVal) ? MaxDimVal : d;
  endfunction

endpackage

[rtl/core/mckb_regs.sv]
// ----------------------------------------------------------------------------
// mckb_regs
// apb configuration registers of the blitter, decoded into cfg_t
// ----------------------------------------------------------------------------
module mckb_regs import mckb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  logic [OrigW-1:0]  dst_x_q, dst_y_q, src_x_q, src_y_q;
  logic [PixW-1:0]   key_q;
  logic [2*DimW-1:0] dst_dims_q, src_dims_q, mask_dims_q;
  reg_idx_e          idx;
  logic              wr_en;

  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dst_x_q     <= '0;
      dst_y_q     <= '0;
      src_x_q     <= '0;
      src_y_q     <= '0;
      key_q       <= '0;
      dst_dims_q  <= '0;
      src_dims_q  <= '0;
      mask_dims_q <= '0;
    end else if (wr_en) begin
      case (idx)
        RegDstOriginX: dst_x_q     <= pwdata[OrigW-1:0];
        RegDstOriginY: dst_y_q     <= pwdata[OrigW-1:0];
        RegSrcOriginX: src_x_q     <= pwdata[OrigW-1:0];
        RegSrcOriginY: src_y_q     <= pwdata[OrigW-1:0];
        RegKeyColor:   key_q       <= pwdata;
        RegDstDims:    dst_dims_q  <= pwdata[2*DimW-1:0];
        RegSrcDims:    src_dims_q  <= pwdata[2*DimW-1:0];
        RegMaskDims:   mask_dims_q <= pwdata[2*DimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegDstOriginX: prdata = {{(32-OrigW){1'b0}}, dst_x_q};
      RegDstOriginY: prdata = {{(32-OrigW){1'b0}}, dst_y_q};
      RegSrcOriginX: prdata = {{(32-OrigW){1'b0}}, src_x_q};
      RegSrcOriginY: prdata = {{(32-OrigW){1'b0}}, src_y_q};
      RegKeyColor:   prdata = key_q;
      RegDstDims:    prdata = {{(32-2*DimW){1'b0}}, dst_dims_q};
      RegSrcDims:    prdata = {{(32-2*DimW){1'b0}}, src_dims_q};
      RegMaskDims:   prdata = {{(32-2*DimW){1'b0}}, mask_dims_q};
      default:       prdata = '0;
    endcase
  end

  // width in the upper field, height in the lower one
  always_comb begin
    cfg_o.dst_x  = dst_x_q;
    cfg_o.dst_y  = dst_y_q;
    cfg_o.src_x  = src_x_q;
    cfg_o.src_y  = src_y_q;
    cfg_o.key    = key_q;
    cfg_o.dst_w  = clamp_dim(dst_dims_q[2*DimW-1:DimW]);
    cfg_o.dst_h  = clamp_dim(dst_dims_q[DimW-1:0]);
    cfg_o.src_w  = clamp_dim(src_dims_q[2*DimW-1:DimW]);
    cfg_o.src_h  = clamp_dim(src_dims_q[DimW-1:0]);
    cfg_o.mask_w = clamp_dim(mask_dims_q[2*DimW-1:DimW]);
    cfg_o.mask_h = clamp_dim(mask_dims_q[DimW-1:0]);
  end

endmodule

[rtl/core/masked_color_key_blit.sv]
// ----------------------------------------------------------------------------
// masked_color_key_blit
// masked color-key blitter: one mask raster position per transfer, one
// write decision with destination coordinates per transfer
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                  payload
// -------   ---------  -------------------------  ---------------------------
// in        sink       in_valid_i / in_ready_o    source_pixel_i, mask_pixel_i
// out       source     out_valid_o / out_ready_i  write_enable_o, dest_col_o,
//                                                 dest_row_o, write_color_o,
//                                                 last_o
// cfg       apb slave  psel/penable/pwrite        paddr, pwdata, prdata
//
// - one transfer per clock in and out while the output is not stalled; a
//   taken transfer passes the input register, then the result register
// - throughput is set by the two-entry register pipeline: while the
//   output is stalled the input register still takes one more transfer
// - reset clears the configuration and the raster counters to zero; no
//   clearing pass is needed, the block takes transfers right after reset
// - the raster counters advance on each input transfer, configuration
//   writes never move them
// ----------------------------------------------------------------------------
module masked_color_key_blit import mckb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // pixel input
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [PixW-1:0]   source_pixel_i,
  input  logic [PixW-1:0]   mask_pixel_i,
  // write decisions
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              write_enable_o,
  output logic [CoordW-1:0] dest_col_o,
  output logic [CoordW-1:0] dest_row_o,
  output logic [PixW-1:0]   write_color_o,
  output logic              last_o
);

  cfg_t cfg;

  mckb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // --------------------------------------------------------------------------
  // handshake and pipeline control
  // --------------------------------------------------------------------------
  logic in_fire, s1_adv;
  logic s1_valid_q, out_valid_q;

  assign s1_adv      = !out_valid_q || out_ready_i;
  assign in_ready_o  = !s1_valid_q || s1_adv;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // --------------------------------------------------------------------------
  // raster counters over the mask, stepped on each input transfer
  // --------------------------------------------------------------------------
  logic [CoordW-1:0] col_q, row_q, col_d, row_d;
  logic [DimW-1:0]   col_inc, row_inc;
  logic              mask_empty, last_d;

  assign mask_empty = (cfg.mask_w == '0) || (cfg.mask_h == '0);
  assign col_inc    = {1'b0, col_q} + DimW'(1);
  assign row_inc    = {1'b0, row_q} + DimW'(1);

  always_comb begin
    if (mask_empty) begin
      // empty mask: every position closes the raster
      col_d  = '0;
      row_d  = '0;
      last_d = 1'b1;
    end else if (col_inc >= cfg.mask_w) begin
      // end of line, also catches a column left beyond a shrunk mask
      col_d  = '0;
      last_d = (row_inc >= cfg.mask_h);
      row_d  = last_d ? '0 : row_inc[CoordW-1:0];
    end else begin
      col_d  = col_inc[CoordW-1:0];
      row_d  = row_q;
      last_d = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // input register: pixels plus the window position they belong to
  // --------------------------------------------------------------------------
  logic [PixW-1:0]   s1_src_q, s1_msk_q;
  logic [CoordW-1:0] s1_col_q, s1_row_q;
  logic              s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        col_q      <= col_d;
        row_q      <= row_d;
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_src_q  <= source_pixel_i;
      s1_msk_q  <= mask_pixel_i;
      s1_col_q  <= col_q;
      s1_row_q  <= row_q;
      s1_last_q <= last_d;
    end
  end

  // --------------------------------------------------------------------------
  // write decision: clip against all three images, mask and color key
  // --------------------------------------------------------------------------
  // origin plus offset, one guard bit so a negative sum shows; the sum cannot overflow
  logic [OrigW:0] dx, dy, sx, sy;
  logic           dst_in, src_in, mask_in, pix_ok, en;

  assign dx = {cfg.dst_x[OrigW-1], cfg.dst_x} + {{(OrigW+1-CoordW){1'b0}}, s1_col_q};
  assign dy = {cfg.dst_y[OrigW-1], cfg.dst_y} + {{(OrigW+1-CoordW){1'b0}}, s1_row_q};
  assign sx = {cfg.src_x[OrigW-1], cfg.src_x} + {{(OrigW+1-CoordW){1'b0}}, s1_col_q};
  assign sy = {cfg.src_y[OrigW-1], cfg.src_y} + {{(OrigW+1-CoordW){1'b0}}, s1_row_q};

  // a sum below its bound also proves the bound nonzero
  assign dst_in = !dx[OrigW] && (dx[OrigW-1:0] < {{(OrigW-DimW){1'b0}}, cfg.dst_w})
               && !dy[OrigW] && (dy[OrigW-1:0] < {{(OrigW-DimW){1'b0}}, cfg.dst_h});
  assign src_in = !sx[OrigW] && (sx[OrigW-1:0] < {{(OrigW-DimW){1'b0}}, cfg.src_w})
               && !sy[OrigW] && (sy[OrigW-1:0] < {{(OrigW-DimW){1'b0}}, cfg.src_h});
  assign mask_in = ({1'b0, s1_col_q} < cfg.mask_w) && ({1'b0, s1_row_q} < cfg.mask_h);

  // opaque black mask, visible source alpha, source not the key color
  assign pix_ok = (s1_msk_q == OpaqueBlack) && (s1_src_q[7:0] != 8'h00)
               && (s1_src_q != cfg.key);

  assign en = dst_in && src_in && mask_in && pix_ok;

  // --------------------------------------------------------------------------
  // result register, payload zeroed when no write is made
  // --------------------------------------------------------------------------
  logic              we_q, last_q;
  logic [CoordW-1:0] dcol_q, drow_q;
  logic [PixW-1:0]   color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      we_q    <= en;
      dcol_q  <= en ? dx[CoordW-1:0] : '0;
      drow_q  <= en ? dy[CoordW-1:0] : '0;
      color_q <= en ? s1_src_q : '0;
      last_q  <= s1_last_q;
    end
  end

  assign write_enable_o = we_q;
  assign dest_col_o     = dcol_q;
  assign dest_row_o     = drow_q;
  assign write_color_o  = color_q;
  assign last_o         = last_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // an empty mask closes the raster on every position
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && mask_empty |=> s1_last_q)
    else $error("empty mask transfer not marked last");

  // a write never carries a transparent pixel
  a_we_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_enable_o |-> write_color_o[7:0] != 8'h00)
    else $error("write enabled for transparent source pixel");

  // no write means an all-zero payload
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_enable_o |->
      dest_col_o == '0 && dest_row_o == '0 && write_color_o == '0)
    else $error("payload not cleared on disabled write");

  // an empty mask holds the raster counters at zero
  a_cnt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && mask_empty |=> col_q == '0 && row_q == '0)
    else $error("raster counters moved on empty mask");

endmodule
